// ===== hw/rtl/dst_ofs_pkg.sv =====
// ----------------------------------------------------------------------------
// dst_ofs_pkg - shared constants and helpers for the DST offset block
// Calendar bounds, reciprocal constants, register map and a small mod-7 helper.
// ----------------------------------------------------------------------------
package dst_ofs_pkg;

    // Register map (index = paddr[2])
    localparam logic REG_ZONE_OFFSET = 1'b0;

    // Valid span: 2000-01-01 00:00:00 .. 2099-12-31 23:59:59
    localparam logic [31:0] FIRST_VALID_SEC = 32'd946684800;
    localparam logic [31:0] LAST_VALID_SEC  = 32'd4102444799;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] DST_EDGE_SECS = 17'd7200;    // 02:00 into the day
    localparam logic [11:0] DST_SECS      = 12'd3600;
    localparam logic [15:0] EPOCH_TO_2000_DAYS = 16'd10957;

    // (t >> 7) / 675 == t / 86400, exact for 25-bit dividends
    localparam logic [25:0] DAY_RECIP       = 26'd50903317;
    localparam int          DAY_RECIP_SHIFT = 35;

    // d / 1461, exact for 16-bit dividends
    localparam logic [15:0] CYCLE_RECIP       = 16'd45934;
    localparam int          CYCLE_RECIP_SHIFT = 26;
    localparam logic [15:0] CYCLE_DAYS        = 16'd1461;

    // Start of each year in a four-year cycle (first year is the leap year)
    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;

    // Day-of-year starts in a common year
    localparam logic [8:0] MAR_START = 9'd59;
    localparam logic [8:0] APR_START = 9'd90;
    localparam logic [8:0] NOV_START = 9'd304;
    localparam logic [8:0] DEC_START = 9'd334;

    // Weekday offset: first of March / November in cycle q, year y is
    // Sunday-based weekday (WD_BASE + 5q + y) mod 7
    localparam logic [7:0] WD_BASE = 8'd10;

    // x mod 7 for an 8-bit x, by reciprocal 293 / 2^11
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [18:0] prod;
        logic [7:0]  quot;
        logic [7:0]  rem;
        prod = 19'(x) * 19'd293;
        quot = prod[18:11];
        rem  = x - 8'(quot * 8'd7);
        return rem[2:0];
    endfunction

endpackage

// ===== hw/rtl/dst_offset_from_epoch_top.sv =====
// ----------------------------------------------------------------------------
// dst_offset_from_epoch_top - US daylight saving decision for a local time
// Seven-stage pipeline from Unix seconds to DST flag and total zone offset.
// ----------------------------------------------------------------------------
// Takes a local wall-clock time in Unix seconds and tells whether US daylight
// saving time applies: always in April..October, in March from 02:00 on the
// second Sunday, in November until 02:00 on the first Sunday, never in
// January, February or December. Times before 2000 or after 2099 are clamped
// to the nearest end of that span and flagged out_of_range. One word is taken
// per clock as long as the result side accepts, through a seven-stage
// pipeline. Back-pressure on the result side stalls only the stages that are
// full, so bubbles are squeezed out. zone_offset is programmed over the APB
// port at byte address 0 and is applied in the last stage; change it only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module dst_offset_from_epoch_top
(
    input  logic               clk,
    input  logic               rst_n,

    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    // Time word in
    input  logic               time_valid,
    output logic               time_ready,
    input  logic [31:0]        local_time,

    // Result word out
    output logic               result_valid,
    input  logic               result_ready,
    output logic               dst_active,
    output logic [11:0]        dst_offset,
    output logic signed [16:0] total_offset,
    output logic               out_of_range
);

    localparam int NUM_STAGES = 7;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic signed [16:0] zone_offset_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == dst_ofs_pkg::REG_ZONE_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            zone_offset_reg <= signed'(pwdata[16:0]);
        end
    end

    always_comb
    begin
        if (paddr[2] == dst_ofs_pkg::REG_ZONE_OFFSET)
        begin
            prdata = {{15{zone_offset_reg[16]}}, zone_offset_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage control: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign time_ready   = stage_en[0];
    assign result_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= time_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp to the 2000..2099 span
    // ------------------------------------------------------------------
    logic [31:0] s1_time_reg, s1_time_next;
    logic        s1_oor_reg,  s1_oor_next;

    always_comb
    begin
        s1_time_next = local_time;
        s1_oor_next  = 1'b0;
        if (local_time < dst_ofs_pkg::FIRST_VALID_SEC)
        begin
            s1_time_next = dst_ofs_pkg::FIRST_VALID_SEC;
            s1_oor_next  = 1'b1;
        end
        else if (local_time > dst_ofs_pkg::LAST_VALID_SEC)
        begin
            s1_time_next = dst_ofs_pkg::LAST_VALID_SEC;
            s1_oor_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_time_reg <= s1_time_next;
            s1_oor_reg  <= s1_oor_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: day number since 1970 via reciprocal of 86400
    // ------------------------------------------------------------------
    logic [50:0] s2_prod;
    logic [15:0] s2_days_reg, s2_days_next;
    logic [31:0] s2_time_reg;
    logic        s2_oor_reg;

    assign s2_prod      = 51'(s1_time_reg[31:7]) * 51'(dst_ofs_pkg::DAY_RECIP);
    assign s2_days_next = 16'(s2_prod >> dst_ofs_pkg::DAY_RECIP_SHIFT);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_days_reg <= s2_days_next;
            s2_time_reg <= s1_time_reg;
            s2_oor_reg  <= s1_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: seconds into the day, day number since 2000
    // ------------------------------------------------------------------
    logic [31:0] s3_day_base;
    logic [16:0] s3_sod;
    logic [15:0] s3_d_reg, s3_d_next;
    logic        s3_late_reg, s3_late_next;   // at or after 02:00
    logic        s3_oor_reg;

    assign s3_day_base  = 32'(s2_days_reg) * 32'(dst_ofs_pkg::SECS_PER_DAY);
    assign s3_sod       = 17'(s2_time_reg - s3_day_base);
    assign s3_late_next = (s3_sod >= dst_ofs_pkg::DST_EDGE_SECS);
    assign s3_d_next    = s2_days_reg - dst_ofs_pkg::EPOCH_TO_2000_DAYS;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_d_reg    <= s3_d_next;
            s3_late_reg <= s3_late_next;
            s3_oor_reg  <= s2_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: four-year cycle number
    // ------------------------------------------------------------------
    logic [31:0] s4_prod;
    logic [4:0]  s4_cyc_reg, s4_cyc_next;
    logic [15:0] s4_d_reg;
    logic        s4_late_reg;
    logic        s4_oor_reg;

    assign s4_prod     = 32'(s3_d_reg) * 32'(dst_ofs_pkg::CYCLE_RECIP);
    assign s4_cyc_next = 5'(s4_prod >> dst_ofs_pkg::CYCLE_RECIP_SHIFT);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s4_cyc_reg  <= s4_cyc_next;
            s4_d_reg    <= s3_d_reg;
            s4_late_reg <= s3_late_reg;
            s4_oor_reg  <= s3_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: year within cycle and day of year
    // ------------------------------------------------------------------
    logic [15:0] s5_cyc_base;
    logic [10:0] s5_rem;
    logic [10:0] s5_year_base;
    logic [1:0]  s5_yic_reg, s5_yic_next;
    logic [8:0]  s5_doy_reg, s5_doy_next;
    logic [4:0]  s5_cyc_reg;
    logic        s5_late_reg;
    logic        s5_oor_reg;

    assign s5_cyc_base = 16'(s4_cyc_reg) * dst_ofs_pkg::CYCLE_DAYS;
    assign s5_rem      = 11'(s4_d_reg - s5_cyc_base);

    always_comb
    begin
        if (s5_rem < dst_ofs_pkg::YEAR1_START)
        begin
            s5_yic_next  = 2'd0;
            s5_year_base = '0;
        end
        else if (s5_rem < dst_ofs_pkg::YEAR2_START)
        begin
            s5_yic_next  = 2'd1;
            s5_year_base = dst_ofs_pkg::YEAR1_START;
        end
        else if (s5_rem < dst_ofs_pkg::YEAR3_START)
        begin
            s5_yic_next  = 2'd2;
            s5_year_base = dst_ofs_pkg::YEAR2_START;
        end
        else
        begin
            s5_yic_next  = 2'd3;
            s5_year_base = dst_ofs_pkg::YEAR3_START;
        end
        s5_doy_next = 9'(s5_rem - s5_year_base);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s5_yic_reg  <= s5_yic_next;
            s5_doy_reg  <= s5_doy_next;
            s5_cyc_reg  <= s4_cyc_reg;
            s5_late_reg <= s4_late_reg;
            s5_oor_reg  <= s4_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: month class, day of month, weekday of the 1st
    // ------------------------------------------------------------------
    logic [8:0] s6_leap;
    logic [8:0] s6_mar, s6_apr, s6_nov, s6_dec;
    logic       s6_is_mar_reg, s6_is_mar_next;
    logic       s6_is_nov_reg, s6_is_nov_next;
    logic       s6_summer_reg, s6_summer_next;
    logic [4:0] s6_dom_reg,    s6_dom_next;      // day of month, from 0
    logic [2:0] s6_wd_reg,     s6_wd_next;       // weekday of the 1st, 0 = Sunday
    logic [7:0] s6_wd_sum;
    logic       s6_late_reg;
    logic       s6_oor_reg;

    assign s6_leap = (s5_yic_reg == 2'd0) ? 9'd1 : 9'd0;
    assign s6_mar  = dst_ofs_pkg::MAR_START + s6_leap;
    assign s6_apr  = dst_ofs_pkg::APR_START + s6_leap;
    assign s6_nov  = dst_ofs_pkg::NOV_START + s6_leap;
    assign s6_dec  = dst_ofs_pkg::DEC_START + s6_leap;

    assign s6_is_mar_next = (s5_doy_reg >= s6_mar) && (s5_doy_reg < s6_apr);
    assign s6_summer_next = (s5_doy_reg >= s6_apr) && (s5_doy_reg < s6_nov);
    assign s6_is_nov_next = (s5_doy_reg >= s6_nov) && (s5_doy_reg < s6_dec);
    assign s6_dom_next    = s6_is_mar_next ? 5'(s5_doy_reg - s6_mar)
                                           : 5'(s5_doy_reg - s6_nov);

    // March 1st and November 1st share a weekday offset within the year
    assign s6_wd_sum  = dst_ofs_pkg::WD_BASE + 8'(s5_cyc_reg) * 8'd5 + 8'(s5_yic_reg);
    assign s6_wd_next = dst_ofs_pkg::mod7(s6_wd_sum);

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            s6_is_mar_reg <= s6_is_mar_next;
            s6_is_nov_reg <= s6_is_nov_next;
            s6_summer_reg <= s6_summer_next;
            s6_dom_reg    <= s6_dom_next;
            s6_wd_reg     <= s6_wd_next;
            s6_late_reg   <= s5_late_reg;
            s6_oor_reg    <= s5_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: Sunday rule, offsets, output register
    // ------------------------------------------------------------------
    logic [4:0]         s7_first_sun;    // day of month of the first Sunday
    logic [4:0]         s7_second_sun;
    logic               s7_dst_mar;
    logic               s7_dst_nov;
    logic               s7_dst_next;
    logic [11:0]        s7_dst_ofs_next;
    logic signed [16:0] s7_total_next;

    logic               dst_active_reg;
    logic [11:0]        dst_offset_reg;
    logic signed [16:0] total_offset_reg;
    logic               out_of_range_reg;

    assign s7_first_sun  = (s6_wd_reg == 3'd0) ? 5'd0 : 5'(3'd7 - s6_wd_reg);
    assign s7_second_sun = s7_first_sun + 5'd7;

    // on from 02:00 on the second Sunday of March
    assign s7_dst_mar = (s6_dom_reg > s7_second_sun)
                        || ((s6_dom_reg == s7_second_sun) && s6_late_reg);
    // on until 02:00 on the first Sunday of November
    assign s7_dst_nov = (s6_dom_reg < s7_first_sun)
                        || ((s6_dom_reg == s7_first_sun) && !s6_late_reg);

    assign s7_dst_next = s6_summer_reg
                         || (s6_is_mar_reg && s7_dst_mar)
                         || (s6_is_nov_reg && s7_dst_nov);

    assign s7_dst_ofs_next = s7_dst_next ? dst_ofs_pkg::DST_SECS : '0;
    assign s7_total_next   = zone_offset_reg + signed'(17'(s7_dst_ofs_next));

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            dst_active_reg   <= s7_dst_next;
            dst_offset_reg   <= s7_dst_ofs_next;
            total_offset_reg <= s7_total_next;
            out_of_range_reg <= s6_oor_reg;
        end
    end

    assign dst_active   = dst_active_reg;
    assign dst_offset   = dst_offset_reg;
    assign total_offset = total_offset_reg;
    assign out_of_range = out_of_range_reg;

endmodule
